/* hw/rtl/hit_angular_distance_defines.svh */
// Assertion macros shared by the RTL files of the angular distance block.
// Define ASSERT_OFF to compile them away.
`ifndef HIT_ANGULAR_DISTANCE_DEFINES_SVH
`define HIT_ANGULAR_DISTANCE_DEFINES_SVH
`ifndef ASSERT_OFF
`define HAD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HAD_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define HAD_ASSERT(lbl, clk, rst, prop, msg)
`define HAD_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

/* hw/rtl/hit_ad_pkg.sv */
`default_nettype none
package hit_ad_pkg;

   // Angle accumulator: a full turn is 2^ACC_BITS.
   localparam int ACC_BITS = 32;
   localparam int CORDIC_ITERS = 32;
   // Vectors are scaled up until one component reaches 2^NORM_EXP.
   localparam int NORM_EXP = 29;
   localparam logic [ACC_BITS-1:0] ANGLE_PI = 32'h8000_0000;

   // atan(2^-i) as a binary angle.
   localparam logic [ACC_BITS-1:0] CORDIC_ATAN [CORDIC_ITERS] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C,
      32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
      32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051,
      32'h0000_0028, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
      32'h0000_0002, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000
   };

endpackage
`default_nettype wire

/* hw/rtl/hit_ad_sqrt.sv */
`default_nettype none
// Pipelined integer square root, one result bit per stage, with remainder.
module hit_ad_sqrt #(
   parameter int IN_W = 64,
   parameter int SIDE_W = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [IN_W-1:0]          in_rad,
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   output logic [(IN_W+1)/2-1:0]    out_root,
   output logic [(IN_W+1)/2+3:0]    out_rem,
   output logic [SIDE_W-1:0]        out_side
);
   localparam int N = (IN_W + 1) / 2;
   localparam int PW = 2 * N;
   localparam int RW = N + 4;

   logic [PW-1:0]     rad_ff [N];
   logic [RW-1:0]     rem_ff [N];
   logic [N-1:0]      q_ff [N];
   logic              v_ff [N];
   logic [SIDE_W-1:0] s_ff [N];

   for (genvar j = 0; j < N; j++) begin : g_stage
      logic [PW-1:0]     radp;
      logic [RW-1:0]     remp;
      logic [N-1:0]      qp;
      logic              vp;
      logic [SIDE_W-1:0] sp;
      logic [RW-1:0]     rem_t;
      logic [RW-1:0]     trial;
      logic [RW-1:0]     rem_in;
      logic [N-1:0]      q_in;

      if (j == 0) begin : g_first
         assign radp = PW'(in_rad);
         assign remp = '0;
         assign qp   = '0;
         assign vp   = in_valid;
         assign sp   = in_side;
      end else begin : g_next
         assign radp = rad_ff[j-1];
         assign remp = rem_ff[j-1];
         assign qp   = q_ff[j-1];
         assign vp   = v_ff[j-1];
         assign sp   = s_ff[j-1];
      end

      always_comb begin
         rem_t = {remp[RW-3:0], radp[PW-1 -: 2]};
         trial = RW'({qp, 2'b01});
         if (rem_t >= trial) begin
            rem_in = rem_t - trial;
            q_in   = {qp[N-2:0], 1'b1};
         end else begin
            rem_in = rem_t;
            q_in   = {qp[N-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en) begin
            v_ff[j] <= vp;
         end
         if (en) begin
            rad_ff[j] <= radp << 2;
            rem_ff[j] <= rem_in;
            q_ff[j]   <= q_in;
            s_ff[j]   <= sp;
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_root  = q_ff[N-1];
   assign out_rem   = rem_ff[N-1];
   assign out_side  = s_ff[N-1];

endmodule
`default_nettype wire

/* hw/rtl/hit_ad_cordic.sv */
`default_nettype none
// Pipelined vectoring CORDIC: atan2(in_y, in_x) as a 32-bit binary angle.
// Two stages scale and fold the vector, then one stage per iteration.
module hit_ad_cordic #(
   parameter int IN_W = 24,
   parameter int SIDE_W = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [IN_W-1:0]            in_y,
   input  logic signed [IN_W-1:0]            in_x,
   input  logic [SIDE_W-1:0]                 in_side,
   output logic                              out_valid,
   output logic [hit_ad_pkg::ACC_BITS-1:0]   out_angle,
   output logic [SIDE_W-1:0]                 out_side
);
   import hit_ad_pkg::*;

   localparam int MW = (IN_W > NORM_EXP + 1) ? IN_W : NORM_EXP + 1;
   localparam int W = MW + 3;
   localparam int KW = $clog2(NORM_EXP + 1);

   logic signed [W-1:0] xe, ye;
   logic [W-1:0]        ax, ay;
   logic [KW-1:0]       ka_in;

   logic signed [W-1:0] xa_ff, ya_ff;
   logic [KW-1:0]       ka_ff;
   logic [SIDE_W-1:0]   sa_ff;
   logic                va_ff;

   logic signed [W-1:0] xs, ys, xb_in, yb_in;
   logic [ACC_BITS-1:0] ab_in;

   logic signed [W-1:0] xb_ff, yb_ff;
   logic [ACC_BITS-1:0] ab_ff;
   logic [SIDE_W-1:0]   sb_ff;
   logic                vb_ff;

   // Scale count: smallest shift that brings one component to 2^NORM_EXP.
   always_comb begin
      xe = W'(in_x);
      ye = W'(in_y);
      ax = xe[W-1] ? W'(-xe) : W'(xe);
      ay = ye[W-1] ? W'(-ye) : W'(ye);
      ka_in = '0;
      for (int kk = NORM_EXP; kk >= 0; kk--) begin
         if ((ax >= (W'(1) << (NORM_EXP - kk))) || (ay >= (W'(1) << (NORM_EXP - kk)))) begin
            ka_in = KW'(kk);
         end
      end
   end

   // A vector in the left half plane is turned by pi first.
   always_comb begin
      xs = xa_ff <<< ka_ff;
      ys = ya_ff <<< ka_ff;
      if (xs < 0) begin
         xb_in = -xs;
         yb_in = -ys;
         ab_in = ANGLE_PI;
      end else begin
         xb_in = xs;
         yb_in = ys;
         ab_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
      if (en) begin
         xa_ff <= xe;
         ya_ff <= ye;
         ka_ff <= ka_in;
         sa_ff <= in_side;
         xb_ff <= xb_in;
         yb_ff <= yb_in;
         ab_ff <= ab_in;
         sb_ff <= sa_ff;
      end
   end

   logic signed [W-1:0] x_ff [CORDIC_ITERS];
   logic signed [W-1:0] y_ff [CORDIC_ITERS];
   logic [ACC_BITS-1:0] a_ff [CORDIC_ITERS];
   logic                v_ff [CORDIC_ITERS];
   logic [SIDE_W-1:0]   s_ff [CORDIC_ITERS];

   for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
      logic signed [W-1:0] xp, yp;
      logic [ACC_BITS-1:0] ap;
      logic                vp;
      logic [SIDE_W-1:0]   sp;

      if (i == 0) begin : g_first
         assign xp = xb_ff;
         assign yp = yb_ff;
         assign ap = ab_ff;
         assign vp = vb_ff;
         assign sp = sb_ff;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign ap = a_ff[i-1];
         assign vp = v_ff[i-1];
         assign sp = s_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= vp;
         end
         if (en) begin
            s_ff[i] <= sp;
            if (yp > 0) begin
               x_ff[i] <= xp + (yp >>> i);
               y_ff[i] <= yp - (xp >>> i);
               a_ff[i] <= ap + CORDIC_ATAN[i];
            end else if (yp < 0) begin
               x_ff[i] <= xp - (yp >>> i);
               y_ff[i] <= yp + (xp >>> i);
               a_ff[i] <= ap - CORDIC_ATAN[i];
            end else begin
               x_ff[i] <= xp;
               y_ff[i] <= yp;
               a_ff[i] <= ap;
            end
         end
      end
   end

   assign out_valid = v_ff[CORDIC_ITERS-1];
   assign out_angle = a_ff[CORDIC_ITERS-1];
   assign out_side  = s_ff[CORDIC_ITERS-1];

endmodule
`default_nettype wire

/* hw/rtl/hit_angular_distance.sv */
// Angular distance between a hit position and a reference direction.
// Input channel req_*: one word carries hit x, y, z and the reference
// azimuth and polar angle. Result channel rsp_*: one word carries the
// distance sqrt(dphi^2 + dtheta^2) on the binary angle scale, where a half
// turn is 2^(ANGLE_BITS-1). Both channels use valid/ready.
// Throughput is one word per cycle. A word is registered at the accepting
// edge and then passes 76 + ANGLE_BITS more register stages (92 at the
// default width): a squaring front end, a 32-stage square root for the
// transverse radius, two 34-stage CORDIC units in parallel for azimuth and
// polar angle, three stages that form the differences, their squares and
// the sum, a final square root of ANGLE_BITS + 2 stages and the output
// register.
// Reset clears every valid bit; nothing else needs clearing, and the block
// takes words in the first cycle after reset.
// When the receiver holds rsp_ready low with a word waiting, the whole
// pipeline freezes and req_ready drops in the same cycle; no word is lost
// or repeated, and flow resumes as soon as the waiting word is taken.
`default_nettype none
`include "hit_angular_distance_defines.svh"
module hit_angular_distance #(
   parameter int COORD_BITS = 24,
   parameter int ANGLE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_hit_x,
   input  logic signed [COORD_BITS-1:0] req_hit_y,
   input  logic signed [COORD_BITS-1:0] req_hit_z,
   input  logic signed [ANGLE_BITS-1:0] req_ref_phi,
   input  logic [ANGLE_BITS-1:0]        req_ref_theta,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ANGLE_BITS-1:0]        rsp_angular_distance
);
   import hit_ad_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int AB = ANGLE_BITS;
   localparam int SW = 2 * CB;                    // x^2 + y^2
   localparam int CW = 2 * CB + 2 * AB;           // carried x, y, phi, theta
   localparam int ZW = ((CB > 31) ? CB : 31) + 1; // scaled z
   localparam int KW = 5;                         // radius scale count, 0..30
   localparam int RAD_W = 64;
   localparam int ROOT_W = RAD_W / 2;
   localparam int TH_IN_W = ROOT_W + 1;
   localparam int SQ_SIDE_W = CW + 1 + ZW;
   localparam int QW = 2 * AB + 3;                // dphi^2 + dtheta^2
   localparam int DN = (QW + 1) / 2;
   localparam int DRW = DN + 4;
   localparam logic [RAD_W-1:0] S_LIMIT = RAD_W'(1) << 58;
   localparam logic [RAD_W-1:0] Z_LIMIT = RAD_W'(1) << NORM_EXP;
   localparam logic [AB-1:0] AMASK = '1;

   // The pipeline moves as a whole unless a finished word is waiting.
   logic rsp_valid_ff;
   logic en;
   assign en = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // Stage 0: input register.
   logic              v0_ff;
   logic [CW-1:0]     c0_ff;
   logic signed [CB-1:0] z0_ff;

   // Stage 1: squares of x and y.
   logic signed [CB-1:0] x0, y0;
   logic signed [SW-1:0] xsq, ysq;
   logic              v1_ff;
   logic [CW-1:0]     c1_ff;
   logic signed [CB-1:0] z1_ff;
   logic [SW-1:0]     xx1_ff, yy1_ff;

   // Stage 2: sum of squares.
   logic              v2_ff;
   logic [CW-1:0]     c2_ff;
   logic signed [CB-1:0] z2_ff;
   logic [SW-1:0]     s2_ff;

   // Stage 3: scale count for the radius and z.
   logic signed [CB:0] ze;
   logic [RAD_W-1:0]  az64, s64;
   logic [KW-1:0]     k3_in;
   logic              v3_ff;
   logic [CW-1:0]     c3_ff;
   logic signed [CB-1:0] z3_ff;
   logic [SW-1:0]     s3_ff;
   logic [KW-1:0]     k3_ff;
   logic              sz3_ff;

   // Stage 4: scaled radicand and z.
   logic signed [ZW-1:0] zt;
   logic              v4_ff;
   logic [CW-1:0]     c4_ff;
   logic signed [ZW-1:0] z4_ff;
   logic [RAD_W-1:0]  s4_ff;
   logic              sz4_ff;

   always_comb begin
      x0  = $signed(c0_ff[CW-1 -: CB]);
      y0  = $signed(c0_ff[CW-CB-1 -: CB]);
      xsq = x0 * x0;
      ysq = y0 * y0;
   end

   // The hit is scaled up (radicand by 4, z by 2 a step) until the radicand
   // passes 2^58 or z reaches 2^NORM_EXP. Find the step count in one go.
   always_comb begin
      ze = (CB+1)'(z2_ff);
      az64 = ze[CB] ? RAD_W'(-ze) : RAD_W'(ze);
      s64 = RAD_W'(s2_ff);
      k3_in = '0;
      for (int kk = 30; kk >= 0; kk--) begin
         if ((s64 > (S_LIMIT >> (2 * kk))) || (az64 >= (Z_LIMIT >> kk))) begin
            k3_in = KW'(kk);
         end
      end
   end

   assign zt = ZW'(z3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      if (en) begin
         c0_ff  <= {req_hit_x, req_hit_y, req_ref_phi, req_ref_theta};
         z0_ff  <= req_hit_z;
         c1_ff  <= c0_ff;
         z1_ff  <= z0_ff;
         xx1_ff <= $unsigned(xsq);
         yy1_ff <= $unsigned(ysq);
         c2_ff  <= c1_ff;
         z2_ff  <= z1_ff;
         s2_ff  <= xx1_ff + yy1_ff;
         c3_ff  <= c2_ff;
         z3_ff  <= z2_ff;
         s3_ff  <= s2_ff;
         k3_ff  <= k3_in;
         sz3_ff <= (s2_ff == '0);
         c4_ff  <= c3_ff;
         z4_ff  <= zt <<< k3_ff;
         s4_ff  <= RAD_W'(s3_ff) << {k3_ff, 1'b0};
         sz4_ff <= sz3_ff;
      end
   end

   // Transverse radius.
   logic                 sq_valid;
   logic [ROOT_W-1:0]    sq_root;
   logic [SQ_SIDE_W-1:0] sq_side;

   hit_ad_sqrt #(
      .IN_W   (RAD_W),
      .SIDE_W (SQ_SIDE_W)
   ) u_radius_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v4_ff),
      .in_rad    (s4_ff),
      .in_side   ({c4_ff, sz4_ff, z4_ff}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_rem   (),
      .out_side  (sq_side)
   );

   logic signed [CB-1:0] x5, y5;
   logic [AB-1:0]        ph5, th5;
   logic                 sz5;
   logic signed [ZW-1:0] z5;

   assign x5  = $signed(sq_side[SQ_SIDE_W-1 -: CB]);
   assign y5  = $signed(sq_side[SQ_SIDE_W-CB-1 -: CB]);
   assign ph5 = sq_side[ZW+1+AB +: AB];
   assign th5 = sq_side[ZW+1 +: AB];
   assign sz5 = sq_side[ZW];
   assign z5  = $signed(sq_side[ZW-1:0]);

   // Azimuth and polar angle run side by side with equal latency.
   logic                th_valid;
   logic [ACC_BITS-1:0] th_angle;
   logic [2*AB-1:0]     th_side;
   logic [ACC_BITS-1:0] ph_angle;
   logic                ph_side;

   hit_ad_cordic #(
      .IN_W   (TH_IN_W),
      .SIDE_W (2 * AB)
   ) u_theta_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_y      ($signed({1'b0, sq_root})),
      .in_x      (TH_IN_W'(z5)),
      .in_side   ({ph5, th5}),
      .out_valid (th_valid),
      .out_angle (th_angle),
      .out_side  (th_side)
   );

   hit_ad_cordic #(
      .IN_W   (CB),
      .SIDE_W (1)
   ) u_phi_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_y      (y5),
      .in_x      (x5),
      .in_side   (sz5),
      .out_valid (),
      .out_angle (ph_angle),
      .out_side  (ph_side)
   );

   // Round both angles half up to ANGLE_BITS. The azimuth wraps modulo a
   // full turn; the polar angle keeps its carry bit. A hit on the z axis or
   // at the origin has polar angle zero.
   logic [ACC_BITS:0]      ph_r, th_r;
   logic [AB-1:0]          phi_q, rphi;
   logic [AB:0]            theta_q;
   logic [AB-1:0]          rtheta;
   logic signed [AB-1:0]   dphi_in;
   logic signed [AB+1:0]   dth_in;

   always_comb begin
      ph_r = {1'b0, ph_angle} + ((ACC_BITS+1)'(1) << (ACC_BITS - 1 - AB));
      th_r = {1'b0, th_angle} + ((ACC_BITS+1)'(1) << (ACC_BITS - 1 - AB));
      phi_q = ph_r[ACC_BITS-1 -: AB];
      theta_q = ph_side ? '0 : th_r[ACC_BITS -: AB+1];
      rphi = th_side[2*AB-1 -: AB];
      rtheta = th_side[AB-1:0];
      dphi_in = $signed(phi_q - rphi);
      dth_in = $signed((AB+2)'(theta_q) - (AB+2)'(rtheta));
   end

   logic                  vf0_ff, vf1_ff, vf2_ff;
   logic signed [AB-1:0]  dphi_ff;
   logic signed [AB+1:0]  dth_ff;
   logic signed [2*AB-1:0] pphi;
   logic signed [2*AB+3:0] pth;
   logic [2*AB-1:0]       sqphi_ff;
   logic [2*AB+3:0]       sqth_ff;
   logic [QW-1:0]         sum_ff;

   assign pphi = dphi_ff * dphi_ff;
   assign pth  = dth_ff * dth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vf0_ff <= 1'b0;
         vf1_ff <= 1'b0;
         vf2_ff <= 1'b0;
      end else if (en) begin
         vf0_ff <= th_valid;
         vf1_ff <= vf0_ff;
         vf2_ff <= vf1_ff;
      end
      if (en) begin
         dphi_ff  <= dphi_in;
         dth_ff   <= dth_in;
         sqphi_ff <= $unsigned(pphi);
         sqth_ff  <= $unsigned(pth);
         sum_ff   <= QW'(sqphi_ff) + QW'(sqth_ff);
      end
   end

   // Distance: square root rounded to nearest, then saturated.
   logic           ds_valid;
   logic [DN-1:0]  ds_root;
   logic [DRW-1:0] ds_rem;
   logic           ds_side;

   hit_ad_sqrt #(
      .IN_W   (QW),
      .SIDE_W (1)
   ) u_dist_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vf2_ff),
      .in_rad    (sum_ff),
      .in_side   (vf2_ff),
      .out_valid (ds_valid),
      .out_root  (ds_root),
      .out_rem   (ds_rem),
      .out_side  (ds_side)
   );

   logic [DN:0]    d_round;
   logic [AB-1:0]  dist_in;
   logic [AB-1:0]  rsp_dist_ff;

   always_comb begin
      d_round = (DN+1)'(ds_root) + ((ds_rem > DRW'(ds_root)) ? (DN+1)'(1) : '0);
      if (d_round > (DN+1)'(AMASK)) begin
         dist_in = AMASK;
      end else begin
         dist_in = d_round[AB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ds_valid && ds_side;
      end
      if (en) begin
         rsp_dist_ff <= dist_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_angular_distance = rsp_dist_ff;

   // An accepted word always lands in the input stage.
   `HAD_ASSERT(a_accept_loads, clock, reset, (req_valid && req_ready) |=> v0_ff, "accepted word lost at input stage")
   // A stall freezes the pipeline contents, as seen at stage 4.
   `HAD_ASSERT(a_stall_holds, clock, reset, !en |=> $stable(v4_ff) && $stable(s4_ff), "pipeline moved during stall")
   // Back pressure only when a finished word waits at the output.
   `HAD_ASSERT_NEVER(a_no_idle_stall, clock, reset, !req_ready && !rsp_valid, "input stalled with no waiting word")
   // Reset empties the output.
   `HAD_ASSERT(a_reset_clears, clock, 1'b0, reset |=> !rsp_valid, "output valid after reset")

endmodule
`default_nettype wire
